// ===== src/cpo_pkg.sv =====
// Shared constants and types for the pattern-occurrence counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpo_pkg;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned GRAM_LEN    = 3;
  // Pattern length saturates at MAX_PATTERN + 1.
  localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 2);
  localparam int unsigned CNT_W       = 16;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  // Per-beat commands broadcast to every cell.
  typedef struct packed {
    logic pat_shift;
    logic txt_shift;
    logic txt_clr;
  } cpo_cell_ctrl_t;

  // Text beat and pattern restart handed to the result stage.
  typedef struct packed {
    logic txt_acc;
    logic last;
    logic pat_start;
  } cpo_res_ctrl_t;

endpackage

`default_nettype wire

// ===== src/count_pattern_occurrences.sv =====
// Top level of the pattern-occurrence counter: input decode, cell chain, result stage.
// Depends on cpo_pkg, cpo_cell and cpo_result.
`default_nettype none

// Counts every occurrence of a pattern (overlaps included) in a byte stream.
// Send the pattern first as beats with kind_i = 0, last_i on its final byte,
// then the text as beats with kind_i = 1, last_i on its final byte. One
// result beat follows each final text byte: the count, saturating at 65535,
// or a zero count with pattern_error_o set when the pattern is shorter than
// 3 or longer than MAX_PATTERN bytes. A text beat while the pattern is still
// loading closes the pattern; a pattern beat after a finished pattern starts
// a new one and drops any partial text. The pattern stays loaded across texts.
// The block takes one byte per cycle: a chain of MAX_PATTERN cells holds the
// pattern, reversed, beside the newest text bytes, and each cell compares its
// own pair. The all-cells AND is evaluated in the cycle after a text beat;
// the result beat then passes through a pending register and an output register.
// Input stalls only while a finished result waits behind a stalled output.

module count_pattern_occurrences
  import cpo_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             kind_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [CNT_W-1:0]      match_count_o,
  output logic                  pattern_error_o
);

  logic             in_acc;
  logic             pat_acc;
  logic             txt_acc;
  logic             loading_q, loading_d;
  logic [LEN_W-1:0] len_q, len_d, len_base;
  logic             fault;
  logic             txt_clr;
  logic             match;

  cpo_cell_ctrl_t   cell_ctrl;
  cpo_res_ctrl_t    res_ctrl;

  logic [7:0]       pat_chain [MAX_PATTERN];
  logic [7:0]       txt_chain [MAX_PATTERN];
  logic             vld_chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign pat_acc = in_acc && (kind_i == KIND_PATTERN);
  assign txt_acc = in_acc && (kind_i == KIND_TEXT);

  // Pattern length bookkeeping; a beat after a finished pattern restarts it.
  assign len_base = loading_q ? len_q : '0;

  always_comb begin
    len_d     = len_q;
    loading_d = loading_q;
    if (pat_acc) begin
      loading_d = !last_i;
      len_d     = (len_base <= LEN_W'(MAX_PATTERN)) ? len_base + 1'b1 : len_base;
    end else if (txt_acc) begin
      loading_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q <= 1'b1;
      len_q     <= '0;
    end else begin
      loading_q <= loading_d;
      len_q     <= len_d;
    end
  end

  assign fault = (len_q < LEN_W'(GRAM_LEN)) || (len_q > LEN_W'(MAX_PATTERN));

  assign cell_ctrl.pat_shift = pat_acc;
  assign cell_ctrl.txt_shift = txt_acc;
  assign cell_ctrl.txt_clr   = txt_clr;

  // Cell j holds pattern byte len-1-j next to the j-th newest text byte.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0] pat_in;
    logic [7:0] txt_in;
    logic       vld_in;

    if (j == 0) begin : g_head
      assign pat_in = data_byte_i;
      assign txt_in = data_byte_i;
      assign vld_in = 1'b1;
    end else begin : g_body
      assign pat_in = pat_chain[j-1];
      assign txt_in = txt_chain[j-1];
      assign vld_in = vld_chain[j-1] && !txt_clr;
    end

    cpo_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .pat_i     (pat_in),
      .txt_i     (txt_in),
      .txt_vld_i (vld_in),
      .active_i  (len_q > LEN_W'(j)),
      .pat_o     (pat_chain[j]),
      .txt_o     (txt_chain[j]),
      .txt_vld_o (vld_chain[j]),
      .hit_o     (hit[j])
    );
  end

  assign match = !fault && (&hit);

  assign res_ctrl.txt_acc   = txt_acc;
  assign res_ctrl.last      = last_i;
  assign res_ctrl.pat_start = pat_acc && !loading_q;

  cpo_result u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (res_ctrl),
    .match_i         (match),
    .fault_i         (fault),
    .out_stall_i     (out_stall_i),
    .hold_o          (in_stall_o),
    .txt_clr_o       (txt_clr),
    .out_valid_o     (out_valid_o),
    .match_count_o   (match_count_o),
    .pattern_error_o (pattern_error_o)
  );

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_PATTERN + 1))
    else $error("pattern length beyond saturation");

  a_txt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    txt_acc |=> !loading_q)
    else $error("pattern still loading after a text beat");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_acc && !loading_q |=> len_q == LEN_W'(1))
    else $error("new pattern did not restart at length one");

endmodule

`default_nettype wire

// ===== src/cpo_cell.sv =====
// One cell of the compare chain: a pattern byte, a text byte with its valid bit.
// Depends on cpo_pkg.
`default_nettype none

module cpo_cell
  import cpo_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cpo_cell_ctrl_t ctrl_i,
  input  wire logic [7:0]     pat_i,
  input  wire logic [7:0]     txt_i,
  input  wire logic           txt_vld_i,
  input  wire logic           active_i,
  output logic [7:0]          pat_o,
  output logic [7:0]          txt_o,
  output logic                txt_vld_o,
  output logic                hit_o
);

  logic [7:0] pat_q;
  logic [7:0] txt_q;
  logic       txt_vld_q;
  logic       txt_vld_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
    if (ctrl_i.txt_shift) begin
      txt_q <= txt_i;
    end
  end

  always_comb begin
    txt_vld_d = txt_vld_q;
    if (ctrl_i.txt_shift) begin
      txt_vld_d = txt_vld_i;
    end else if (ctrl_i.txt_clr) begin
      txt_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txt_vld_q <= 1'b0;
    end else begin
      txt_vld_q <= txt_vld_d;
    end
  end

  // Cells beyond the pattern length always agree.
  assign hit_o     = !active_i || (txt_vld_q && (pat_q == txt_q));
  assign pat_o     = pat_q;
  assign txt_o     = txt_q;
  assign txt_vld_o = txt_vld_q;

endmodule

`default_nettype wire

// ===== src/cpo_result.sv =====
// Match evaluation stage, saturating counter and output register.
// Depends on cpo_pkg.
`default_nettype none

module cpo_result
  import cpo_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cpo_res_ctrl_t    ctrl_i,
  input  wire logic             match_i,
  input  wire logic             fault_i,
  input  wire logic             out_stall_i,
  output logic                  hold_o,
  output logic                  txt_clr_o,
  output logic                  out_valid_o,
  output logic [CNT_W-1:0]      match_count_o,
  output logic                  pattern_error_o
);

  logic             pend_vld_q, pend_vld_d;
  logic             pend_last_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             out_vld_q, out_vld_d;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_err_q;
  logic             out_free;
  logic             pend_adv;
  logic             emit;

  assign out_free = !out_vld_q || !out_stall_i;
  assign pend_adv = pend_vld_q && (!pend_last_q || out_free);
  assign emit     = pend_adv && pend_last_q;
  assign hold_o   = pend_vld_q && !pend_adv;
  assign cnt_inc  = (match_i && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;

  // Window and count restart after the last text beat or a new pattern.
  assign txt_clr_o = emit || ctrl_i.pat_start;

  always_comb begin
    cnt_d = cnt_q;
    if (txt_clr_o) begin
      cnt_d = '0;
    end else if (pend_adv) begin
      cnt_d = cnt_inc;
    end
  end

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (ctrl_i.txt_acc) begin
      pend_vld_d = 1'b1;
    end else if (pend_adv) begin
      pend_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.txt_acc) begin
      pend_last_q <= ctrl_i.last;
    end
    if (emit) begin
      out_cnt_q <= fault_i ? '0 : cnt_inc;
      out_err_q <= fault_i;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign match_count_o   = out_cnt_q;
  assign pattern_error_o = out_err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_err_q |-> out_cnt_q == '0)
    else $error("error result with non-zero count");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_o |-> pend_last_q && out_vld_q && out_stall_i)
    else $error("pending beat held without a blocked result");

  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !txt_clr_o |=> cnt_q >= $past(cnt_q))
    else $error("count dropped without a clear");

  a_fault_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_adv && fault_i && !txt_clr_o |=> cnt_q == $past(cnt_q))
    else $error("count moved under a faulty pattern");

endmodule

`default_nettype wire

// ===== tb/tb_count_pattern_occurrences.sv =====
// Self-checking bench for count_pattern_occurrences: directed table then random pattern/text runs.
// Depends on cpo_pkg and the count_pattern_occurrences RTL; carries its own occurrence predictor.
`timescale 1ns / 1ps

module tb_count_pattern_occurrences;
  import cpo_pkg::*;

  localparam int unsigned COUNT_SAT   = 65535;
  localparam int unsigned QUIET_LIMIT = 5000;  // cycles with no beat on either side
  localparam int unsigned RAND_ITEMS  = 1050;

  // One result beat: occurrence count plus the bad-length flag.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             err;
  } tally_t;

  // Directed row: reps beats of the same byte, last only on the final one.
  // typed rows carry a hand-written tally, the rest go through the predictor.
  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic             last;
    logic [16:0]      reps;
    logic             typed;
    logic [CNT_W-1:0] cnt;
    logic             err;
  } stim_row_t;

  localparam int unsigned N_ROWS = 28;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // text straight out of reset: empty pattern, so a fault
    '{KIND_TEXT,    8'h00, 1'b1, 17'd1,     1'b1, 16'd0,      1'b1},
    // two-byte pattern is too short
    '{KIND_PATTERN, 8'hFF, 1'b0, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_PATTERN, 8'h80, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'h80, 1'b1, 17'd1,     1'b1, 16'd0,      1'b1},
    // 00 FF 00 against 00 FF 00 FF 00: overlapping hits
    '{KIND_PATTERN, 8'h00, 1'b0, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_PATTERN, 8'hFF, 1'b0, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_PATTERN, 8'h00, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'h00, 1'b0, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'hFF, 1'b0, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'h00, 1'b0, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'hFF, 1'b0, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'h00, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    // pattern never flagged last: the first text byte closes it
    '{KIND_PATTERN, 8'hAA, 1'b0, 17'd3,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'hAA, 1'b0, 17'd3,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'hAA, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    // partial text dropped by a new pattern, which is overlong (34 bytes)
    '{KIND_TEXT,    8'h55, 1'b0, 17'd2,     1'b0, 16'd0,      1'b0},
    '{KIND_PATTERN, 8'h5A, 1'b0, 17'd33,    1'b0, 16'd0,      1'b0},
    '{KIND_PATTERN, 8'h5A, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'h5A, 1'b1, 17'd1,     1'b1, 16'd0,      1'b1},
    // longest legal pattern, 32 x FF
    '{KIND_PATTERN, 8'hFF, 1'b0, 17'd31,    1'b0, 16'd0,      1'b0},
    '{KIND_PATTERN, 8'hFF, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'hFF, 1'b0, 17'd40,    1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'hFF, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    // 00 00 00 vs a text shorter than it: the zeroed window must not hit
    '{KIND_PATTERN, 8'h00, 1'b0, 17'd2,     1'b0, 16'd0,      1'b0},
    '{KIND_PATTERN, 8'h00, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'h00, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0},
    // zero run: every byte from the third on is a hit
    '{KIND_TEXT,    8'h00, 1'b0, 17'd20,    1'b0, 16'd0,      1'b0},
    '{KIND_TEXT,    8'h00, 1'b1, 17'd1,     1'b0, 16'd0,      1'b0}
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             kind_i      = KIND_PATTERN;
  logic [7:0]       data_byte_i = 8'h00;
  logic             last_i      = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [CNT_W-1:0] match_count_o;
  logic             pattern_error_o;

  count_pattern_occurrences dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_count_o  (match_count_o),
    .pattern_error_o(pattern_error_o)
  );

  always begin
    #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the pattern, the text window and
  // the running count. Window index MAX_PATTERN-1 holds the newest byte.
  // ---------------------------------------------------------------------
  logic [7:0]  pat_mem [MAX_PATTERN];
  logic [7:0]  txt_win [MAX_PATTERN];
  int unsigned pat_len     = 0;
  bit          pat_loading = 1'b1;
  bit          pat_fault   = 1'b0;
  int unsigned win_fill    = 0;
  int unsigned run_cnt     = 0;

  tally_t      pending_tallies[$];
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 19;
  int unsigned dst_stall_pct = 51;

  task automatic clear_text();
    for (int i = 0; i < MAX_PATTERN; i++) txt_win[i] = 8'h00;
    win_fill = 0;
    run_cnt  = 0;
  endtask

  task automatic close_pattern();
    pat_loading = 1'b0;
    pat_fault   = (pat_len < GRAM_LEN) || (pat_len > MAX_PATTERN);
  endtask

  // Advances the predictor by one accepted beat; has_res set on a final text byte.
  task automatic predict_tally(input logic k, input logic [7:0] d, input logic l,
                               output bit has_res, output tally_t res);
    bit          hit;
    int unsigned base;
    has_res = 1'b0;
    res     = '0;
    if (k == KIND_PATTERN) begin
      // a pattern beat after a closed pattern restarts the load and drops the text
      if (!pat_loading) begin
        pat_loading = 1'b1;
        pat_len     = 0;
        pat_fault   = 1'b0;
        clear_text();
      end
      if (pat_len < MAX_PATTERN) pat_mem[pat_len] = d;
      if (pat_len <= MAX_PATTERN) pat_len++;
      if (l) close_pattern();
    end else begin
      if (pat_loading) close_pattern();
      for (int i = 0; i < MAX_PATTERN - 1; i++) txt_win[i] = txt_win[i+1];
      txt_win[MAX_PATTERN-1] = d;
      if (win_fill < MAX_PATTERN) win_fill++;
      hit = !pat_fault && (pat_len <= MAX_PATTERN) && (win_fill >= pat_len);
      base = MAX_PATTERN - pat_len;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (hit && i < pat_len && pat_mem[i] != txt_win[base + i]) hit = 1'b0;
      end
      if (hit && run_cnt < COUNT_SAT) run_cnt++;
      if (l) begin
        has_res   = 1'b1;
        res.count = pat_fault ? '0 : CNT_W'(run_cnt);
        res.err   = pat_fault;
        clear_text();
      end
    end
  endtask

  // Drives one beat. Entered and left at a falling edge; random gaps first.
  task automatic send_beat(input logic k, input logic [7:0] d, input logic l,
                           input bit typed = 1'b0, input tally_t want = '0);
    bit     has_res;
    tally_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= d;
    last_i      <= l;
    do @(posedge clk_i); while (in_stall_o);
    predict_tally(k, d, l, has_res, res);
    if (has_res) begin
      pending_tallies.push_back(typed ? want : res);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input side off until every outstanding tally has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_tallies.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < dst_stall_pct);
  end

  // Result checker: every accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result count=%0d err=%0b", match_count_o,
                   pattern_error_o);
      end else begin
        want = pending_tallies.pop_front();
        if (want.count !== match_count_o || want.err !== pattern_error_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: count exp %0d got %0d, error flag exp %0b got %0b",
                     want.count, match_count_o, want.err, pattern_error_o);
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("count_pattern_occurrences test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  motif[$];
    logic [7:0]  txt[$];
    logic [7:0]  base_b;
    logic [7:0]  flip_b;
    int unsigned pick;
    int unsigned plen;
    int unsigned tlen;
    int unsigned rnd_start;
    int unsigned phase;
    bit          close_last;
    bit          abort_txt;
    tally_t      want;

    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_mem[i] = 8'h00;
      txt_win[i] = 8'h00;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int r = 0; r < N_ROWS; r++) begin
      want.count = DIRECTED[r].cnt;
      want.err   = DIRECTED[r].err;
      for (int n = 0; n < DIRECTED[r].reps; n++) begin
        send_beat(DIRECTED[r].kind, DIRECTED[r].data,
                  DIRECTED[r].last && (n == DIRECTED[r].reps - 1),
                  DIRECTED[r].typed, want);
      end
    end
    drain_results();

    // Random runs: mostly a pattern over a small alphabet followed by a text
    // seeded with copies of it, so hits and overlaps are frequent.
    rnd_start   = items_sent;
    phase       = 0;
    while (items_sent - rnd_start < RAND_ITEMS) begin
      // idling phases: sender-light/receiver-heavy, swapped, then none
      if (phase == 0 && items_sent - rnd_start >= RAND_ITEMS / 3) begin
        drain_results();
        phase         = 1;
        src_idle_pct  = 51;
        dst_stall_pct = 19;
      end else if (phase == 1 && items_sent - rnd_start >= 2 * RAND_ITEMS / 3) begin
        drain_results();
        phase         = 2;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
      end

      base_b = 8'($urandom_range(255));
      flip_b = 8'($urandom_range(1, 255));
      pick   = $urandom_range(99);
      // keep the loaded pattern now and then and just send another text
      if (pick >= 20 || motif.size() == 0) begin
        pick = $urandom_range(99);
        if (pick < 70)      plen = $urandom_range(3, 8);
        else if (pick < 82) plen = $urandom_range(9, MAX_PATTERN);
        else if (pick < 92) plen = $urandom_range(1, 2);
        else                plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 3);
        close_last = ($urandom_range(99) < 80);
        motif.delete();
        for (int i = 0; i < plen; i++) begin
          if ($urandom_range(9) == 0) motif.push_back(8'($urandom_range(255)));
          else motif.push_back($urandom_range(1) ? base_b : base_b ^ flip_b);
        end
        for (int i = 0; i < plen; i++)
          send_beat(KIND_PATTERN, motif[i], close_last && (i == plen - 1));
      end

      tlen = $urandom_range(1, 40);
      txt.delete();
      while (txt.size() < tlen) begin
        if ($urandom_range(2) == 0) begin
          foreach (motif[i]) txt.push_back(motif[i]);
        end else begin
          txt.push_back($urandom_range(1) ? motif[0] : motif[0] ^ flip_b);
        end
      end
      // a text cut short runs on into the next text or is dropped by a new pattern
      abort_txt = ($urandom_range(99) < 8);
      foreach (txt[i])
        send_beat(KIND_TEXT, txt[i], !abort_txt && (i == txt.size() - 1));
    end

    in_valid_i <= 1'b0;
    while (pending_tallies.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("count_pattern_occurrences test passed");
    end else begin
      $display("count_pattern_occurrences test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cpo_pkg.sv
src/cpo_cell.sv
src/cpo_result.sv
src/count_pattern_occurrences.sv
tb/tb_count_pattern_occurrences.sv
